@@ rtl/core/sqd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sqd_pkg
// Shared widths, payload types and the byte-to-component table of the
// smallest-three quaternion decoder.
// ----------------------------------------------------------------------------
package sqd_pkg;

  // Fixed-point fraction bits of every component
  localparam int FRAC_BITS = 14;
  localparam int COMP_W    = 16;
  localparam int BYTE_W    = 8;
  localparam int TAB_N     = 256;

  // Dequantized magnitude is below sqrt(2) * 2^F
  localparam int MAG_W  = FRAC_BITS + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int RAD_W  = 2 * FRAC_BITS + 1;
  localparam int ROOT_W = FRAC_BITS + 1;

  localparam logic [BYTE_W-1:0] TAG_BASE = BYTE_W'(252);
  localparam logic [SUM_W-1:0]  ONE_SQ   = SUM_W'(64'd1 << (2 * FRAC_BITS));
  localparam logic [COMP_W-1:0] COMP_ONE = COMP_W'(64'd1 << FRAC_BITS);

  typedef logic [TAB_N-1:0][MAG_W-1:0] mag_tab_t;

  // Item moving through the pipe; the dropped slot is filled at the end
  typedef struct packed {
    logic [3:0][COMP_W-1:0] comps;
    logic [1:0]             drop;
    logic                   ok;
  } pay_t;

  // Integer square root, floor
  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bitv;
    x    = x_in;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // round(d * 2^F / (255 * sqrt2)) for the odd magnitude d = |2p - 255|
  function automatic logic [MAG_W-1:0] dequant_mag(input int p);
    logic [63:0] d;
    logic [63:0] num;
    logic [63:0] q1;
    logic [63:0] r1;
    logic [63:0] zsq;
    logic [63:0] s;
    d   = (p < 128) ? 64'(255 - 2 * p) : 64'(2 * p - 255);
    num = 64'd2 * d * d;
    q1  = num / 64'd65025;
    r1  = num % 64'd65025;
    zsq = (q1 << (2 * FRAC_BITS)) + ((r1 << (2 * FRAC_BITS)) / 64'd65025);
    s   = isqrt64(zsq);
    return MAG_W'((s + 64'd1) >> 1);
  endfunction

  function automatic mag_tab_t build_mag_tab();
    mag_tab_t t;
    for (int p = 0; p < TAB_N; p++) begin
      t[p] = dequant_mag(p);
    end
    return t;
  endfunction

  localparam mag_tab_t MAG_TAB = build_mag_tab();

  // Signed field value of a stored byte, wrapped to the field width
  function automatic logic [COMP_W-1:0] comp_of(input logic [BYTE_W-1:0] p);
    logic [MAG_W:0] m;
    m = {1'b0, MAG_TAB[p]};
    return p[BYTE_W-1] ? COMP_W'(m) : COMP_W'(-m);
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/sqd_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sqd_front
// Table lookup and slot placement, squaring, then sum and radicand.
// Three register stages with a per-stage valid/ready chain.
// ----------------------------------------------------------------------------
module sqd_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [sqd_pkg::BYTE_W-1:0]  byte_a,
  input  wire logic [sqd_pkg::BYTE_W-1:0]  byte_b,
  input  wire logic [sqd_pkg::BYTE_W-1:0]  byte_c,
  input  wire logic [sqd_pkg::BYTE_W-1:0]  mode_tag,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output sqd_pkg::pay_t                    out_pay,
  output logic [sqd_pkg::RAD_W-1:0]        out_rad
);
  import sqd_pkg::*;

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;
  pay_t pay1, pay2, pay3;
  pay_t pay0;
  logic [2:0][MAG_W-1:0] mag1;
  logic [2:0][SQ_W-1:0]  sq2;
  logic [RAD_W-1:0]      rad3;
  logic [COMP_W-1:0] ca, cb, cc;
  logic [SUM_W-1:0]  sum;

  // Stall chain: a stage moves when empty or when the next one moves
  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // Place the three values in ascending slots around the dropped one
  always_comb begin
    ca = comp_of(byte_a);
    cb = comp_of(byte_b);
    cc = comp_of(byte_c);
    pay0.ok   = (mode_tag >= TAG_BASE);
    pay0.drop = mode_tag[1:0];
    pay0.comps = '0;
    if (pay0.ok) begin
      unique case (pay0.drop)
        2'd0:    pay0.comps = {cc, cb, ca, {COMP_W{1'b0}}};
        2'd1:    pay0.comps = {cc, cb, {COMP_W{1'b0}}, ca};
        2'd2:    pay0.comps = {cc, {COMP_W{1'b0}}, cb, ca};
        default: pay0.comps = {{COMP_W{1'b0}}, cc, cb, ca};
      endcase
    end else begin
      pay0.comps = {COMP_ONE, {COMP_W{1'b0}}, {COMP_W{1'b0}}, {COMP_W{1'b0}}};
    end
  end

  // Sum of squares and the clamped radicand
  assign sum = SUM_W'(sq2[0]) + SUM_W'(sq2[1]) + SUM_W'(sq2[2]);

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      pay1    <= pay0;
      mag1[0] <= MAG_TAB[byte_a];
      mag1[1] <= MAG_TAB[byte_b];
      mag1[2] <= MAG_TAB[byte_c];
    end
    if (rdy2 && v1) begin
      pay2   <= pay1;
      sq2[0] <= SQ_W'(mag1[0] * mag1[0]);
      sq2[1] <= SQ_W'(mag1[1] * mag1[1]);
      sq2[2] <= SQ_W'(mag1[2] * mag1[2]);
    end
    if (rdy3 && v2) begin
      pay3 <= pay2;
      rad3 <= (sum < ONE_SQ) ? RAD_W'(ONE_SQ - sum) : '0;
    end
  end

  assign out_valid = v3;
  assign out_pay   = pay3;
  assign out_rad   = rad3;

endmodule
`default_nettype wire

@@ rtl/core/sqd_isqrt.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sqd_isqrt
// Pipelined restoring square root: one root bit per stage, MSB first.
// The item payload rides along with the partial root.
// ----------------------------------------------------------------------------
module sqd_isqrt (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire sqd_pkg::pay_t                in_pay,
  input  wire logic [sqd_pkg::RAD_W-1:0]    in_rad,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output sqd_pkg::pay_t                     out_pay,
  output logic [sqd_pkg::ROOT_W-1:0]        out_root
);
  import sqd_pkg::*;

  localparam int NST  = ROOT_W;
  localparam int TR_W = RAD_W + 2;

  logic                v   [NST];
  logic                rdy [NST];
  pay_t                pay [NST];
  logic [RAD_W-1:0]    rem [NST];
  logic [ROOT_W-1:0]   root[NST];

  assign in_ready = rdy[0];

  for (genvar j = 0; j < NST; j++) begin : g_st
    localparam int B = NST - 1 - j;

    logic              pv;
    pay_t              ppay;
    logic [RAD_W-1:0]  prem;
    logic [ROOT_W-1:0] proot;
    logic [TR_W-1:0]   trial;
    logic              take;

    // Previous stage, or the block input for the first one
    if (j == 0) begin : g_first
      assign pv    = in_valid;
      assign ppay  = in_pay;
      assign prem  = in_rad;
      assign proot = '0;
    end else begin : g_next
      assign pv    = v[j-1];
      assign ppay  = pay[j-1];
      assign prem  = rem[j-1];
      assign proot = root[j-1];
    end

    if (j == NST - 1) begin : g_last_rdy
      assign rdy[j] = !v[j] || out_ready;
    end else begin : g_mid_rdy
      assign rdy[j] = !v[j] || rdy[j+1];
    end

    // (r + 2^B)^2 - r^2 against what is left of the radicand
    always_comb begin
      trial = (TR_W'(proot) << (B + 1)) + (TR_W'(1) << (2 * B));
      take  = (trial <= TR_W'(prem));
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (rdy[j]) begin
        v[j] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j] && pv) begin
        pay[j]  <= ppay;
        rem[j]  <= take ? (prem - RAD_W'(trial)) : prem;
        root[j] <= take ? (proot | (ROOT_W'(1) << B)) : proot;
      end
    end
  end

  assign out_valid = v[NST-1];
  assign out_pay   = pay[NST-1];
  assign out_root  = root[NST-1];

endmodule
`default_nettype wire

@@ rtl/core/smallest_three_quaternion_decode_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// smallest_three_quaternion_decode_core
// Rebuilds a unit quaternion in Q2.14 from three quantized bytes and a tag.
//
//   channel  dir  handshake         payload
//   s_       in   s_tvalid/tready   tdata: byte_a, byte_b, byte_c; tuser: mode_tag
//   m_       out  m_tvalid/tready   tdata: comp_zero..comp_three; tuser: tag_ok
//
// One item per cycle while m_tready is held high. Three front stages (lookup,
// squares, radicand), one square-root stage per root bit, and the output
// register. Each stage holds its item under a stall and takes a new one
// whenever it is empty, so bubbles close up. rst clears the valid bits
// only.
// ----------------------------------------------------------------------------
module smallest_three_quaternion_decode_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // byte_a [7:0], byte_b [15:8], byte_c [23:16]
  input  wire logic [7:0]  s_tuser,   // mode_tag [7:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // comp_zero [15:0], comp_one [31:16],
                                      // comp_two [47:32], comp_three [63:48]
  output logic             m_tuser    // tag_ok
);
  import sqd_pkg::*;

  logic              f_valid, f_ready;
  pay_t              f_pay;
  logic [RAD_W-1:0]  f_rad;
  logic              r_valid, r_ready;
  pay_t              r_pay;
  logic [ROOT_W-1:0] r_root;
  logic              o_ready;
  logic [3:0][COMP_W-1:0] comps_next;

  sqd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .byte_a    (s_tdata[7:0]),
    .byte_b    (s_tdata[15:8]),
    .byte_c    (s_tdata[23:16]),
    .mode_tag  (s_tuser),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_pay   (f_pay),
    .out_rad   (f_rad)
  );

  sqd_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_pay    (f_pay),
    .in_rad    (f_rad),
    .out_valid (r_valid),
    .out_ready (r_ready),
    .out_pay   (r_pay),
    .out_root  (r_root)
  );

  // Drop the root into its slot on a good tag
  always_comb begin
    comps_next = r_pay.comps;
    if (r_pay.ok) begin
      comps_next[r_pay.drop] = COMP_W'(r_root);
    end
  end

  // Output register
  assign o_ready = !m_tvalid || m_tready;
  assign r_ready = o_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (o_ready) begin
      m_tvalid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && r_valid) begin
      m_tdata <= comps_next;
      m_tuser <= r_pay.ok;
    end
  end

  // A bad tag always leaves the identity
  a_ident : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |->
      (m_tdata == {COMP_ONE, {COMP_W{1'b0}}, {COMP_W{1'b0}}, {COMP_W{1'b0}}}))
    else $error("bad tag did not give the identity");

  // An empty output register means the whole pipe can move
  a_ready : assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty output");

  // An item leaving the root pipe while the output is free is captured
  a_capture : assert property (@(posedge clk) disable iff (rst)
    (r_valid && o_ready) |=> m_tvalid)
    else $error("finished item lost at the output register");

endmodule
`default_nettype wire

@@ bench/smallest_three_quaternion_decode_core_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// smallest_three_quaternion_decode_core_tb
// Self-checking bench for the smallest-three quaternion decoder. Items go in
// on the s_ stream with random gaps. Each accepted item is decoded by an
// exact integer model kept here, and the expected quaternion is queued. Every
// m_ result is checked field by field against the oldest queued quaternion.
// The test tasks cover the extreme bytes, every tag class, random traffic, a
// steady stream, a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module smallest_three_quaternion_decode_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC   = sqd_pkg::FRAC_BITS;
  localparam int CW     = sqd_pkg::COMP_W;
  localparam logic [7:0] TAG_FIRST = sqd_pkg::TAG_BASE;
  localparam int TAIL_CYCLES = 40;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 38;

  // Decoded quaternion plus valid flag
  typedef struct packed {
    logic [3:0][CW-1:0] comp;
    logic               ok;
  } quat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // byte_a [7:0], byte_b [15:8], byte_c [23:16]
  logic [7:0]  s_tuser = '0;   // mode_tag [7:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // comp_zero, comp_one, comp_two, comp_three
  logic        m_tuser;        // tag_ok

  quat_t quat_expected[$];
  int    err_count   = 0;
  int    cycle_count = 0;

  // Idle controls and hold-off request, written by the test tasks
  logic tx_idle_on = 1'b1;
  logic rx_idle_on = 1'b1;
  int   hold_seq   = 0;
  int   hold_len   = 0;
  int   hold_seen  = 0;
  int   hold_left  = 0;

  smallest_three_quaternion_decode_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Signed component of a stored byte: largest m with (2m-1)^2 <= 4 v^2,
  // which is v rounded to nearest (v is never a half).
  function automatic longint byte_to_comp(input logic [7:0] p);
    longint d;
    longint target;
    longint m;
    longint trial;
    d      = p[7] ? (2 * longint'(p) - 255) : (255 - 2 * longint'(p));
    target = (2 * d * d) << (2 * FRAC);
    m      = 0;
    for (int b = FRAC + 1; b >= 0; b--) begin
      trial = m | (longint'(1) << b);
      if ((2 * trial - 1) * (2 * trial - 1) * 65025 <= target) begin
        m = trial;
      end
    end
    return p[7] ? m : -m;
  endfunction

  // floor(sqrt(x)) by bitwise search
  function automatic longint floor_root(input longint x);
    longint r;
    longint trial;
    r = 0;
    for (int b = FRAC + 1; b >= 0; b--) begin
      trial = r | (longint'(1) << b);
      if (trial * trial <= x) begin
        r = trial;
      end
    end
    return r;
  endfunction

  // Expected quaternion for one input item
  function automatic quat_t decode_quat(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c, input logic [7:0] tag);
    quat_t  q;
    longint vals[3];
    longint sum;
    longint unit_sq;
    int     drop;
    int     k;
    q       = '0;
    unit_sq = longint'(1) << (2 * FRAC);
    if (tag >= TAG_FIRST) begin
      drop    = int'(tag - TAG_FIRST);
      vals[0] = byte_to_comp(a);
      vals[1] = byte_to_comp(b);
      vals[2] = byte_to_comp(c);
      sum     = 0;
      k       = 0;
      for (int slot = 0; slot < 4; slot++) begin
        if (slot != drop) begin
          q.comp[slot] = CW'(vals[k]);
          sum += vals[k] * vals[k];
          k++;
        end
      end
      q.comp[drop] = CW'(floor_root(sum < unit_sq ? unit_sq - sum : 0));
      q.ok = 1'b1;
    end else begin
      q.comp[3] = CW'(longint'(1) << FRAC);
    end
    return q;
  endfunction

  // Offer one item, with a random gap first when idling is on
  task automatic send_item(input logic [7:0] a, input logic [7:0] b,
                           input logic [7:0] c, input logic [7:0] tag);
    if (tx_idle_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {c, b, a};
    s_tuser  <= tag;
    do @(posedge clk); while (!s_tready);
    quat_expected = {quat_expected, decode_quat(a, b, c, tag)};
    @(negedge clk);
  endtask

  // Mostly valid tags, some invalid, bytes biased toward the ends and the middle now and then
  task automatic send_random_item();
    logic [7:0] bytes[3];
    logic [7:0] tag;
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(9))
        0:       bytes[i] = 8'd0;
        1:       bytes[i] = 8'd255;
        2:       bytes[i] = 8'd127 + 8'($urandom_range(1));
        default: bytes[i] = 8'($urandom_range(255));
      endcase
    end
    if ($urandom_range(99) < 80) begin
      tag = TAG_FIRST + 8'($urandom_range(3));
    end else begin
      tag = 8'($urandom_range(251));
    end
    send_item(bytes[0], bytes[1], bytes[2], tag);
  endtask

  task automatic wait_until_drained();
    s_tvalid <= 1'b0;
    while (quat_expected.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Extreme bytes, every drop slot, invalid tags and the clamped radicand
  task automatic test_directed();
    send_item(8'd0,   8'd0,   8'd0,   8'd252);  // sum over one, root clamps to 0
    send_item(8'd255, 8'd255, 8'd255, 8'd253);
    send_item(8'd127, 8'd128, 8'd127, 8'd254);  // smallest magnitudes
    send_item(8'd128, 8'd128, 8'd128, 8'd255);
    send_item(8'd0,   8'd255, 8'd128, 8'd252);
    send_item(8'd1,   8'd254, 8'd127, 8'd253);
    send_item(8'd255, 8'd0,   8'd127, 8'd254);
    send_item(8'd200, 8'd60,  8'd140, 8'd255);
    send_item(8'd170, 8'd85,  8'd90,  8'd252);
    send_item(8'd85,  8'd170, 8'd165, 8'd253);
    send_item(8'd15,  8'd240, 8'd30,  8'd254);
    send_item(8'd240, 8'd15,  8'd225, 8'd255);
    send_item(8'd40,  8'd70,  8'd128, 8'd252);
    send_item(8'd12,  8'd34,  8'd56,  8'd0);    // invalid tags give identity
    send_item(8'd255, 8'd255, 8'd255, 8'd251);
    send_item(8'd0,   8'd0,   8'd0,   8'd127);
    send_item(8'd99,  8'd1,   8'd200, 8'd128);
    send_item(8'd128, 8'd127, 8'd64,  8'd170);
    send_item(8'd77,  8'd33,  8'd11,  8'd85);
    send_item(8'd255, 8'd0,   8'd255, 8'd255);
  endtask

  task automatic test_random_traffic(input int n);
    for (int i = 0; i < n; i++) begin
      send_random_item();
    end
  endtask

  // No idling on either side
  task automatic test_steady_stream(input int n);
    tx_idle_on <= 1'b0;
    rx_idle_on <= 1'b0;
    for (int i = 0; i < n; i++) begin
      send_random_item();
    end
    tx_idle_on <= 1'b1;
    rx_idle_on <= 1'b1;
  endtask

  // Receiver holds off while the sender keeps offering, so the pipe fills
  task automatic test_output_hold(input int n);
    hold_len   <= 150;
    hold_seq   <= hold_seq + 1;
    tx_idle_on <= 1'b0;
    s_tvalid   <= 1'b0;
    @(negedge clk);
    for (int i = 0; i < n; i++) begin
      send_random_item();
    end
    tx_idle_on <= 1'b1;
  endtask

  // Sender stops until every result is back, then resumes
  task automatic test_drain_pause(input int n);
    for (int i = 0; i < n; i++) begin
      send_random_item();
    end
    wait_until_drained();
    for (int i = 0; i < n; i++) begin
      send_random_item();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random_traffic(300);
    test_steady_stream(150);
    test_output_hold(60);
    test_drain_pause(60);
    test_random_traffic(300);
    wait_until_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Receiver: hold-off counter first, then random or steady ready
  always @(negedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= hold_len;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (rx_idle_on) begin
      m_tready <= ($urandom_range(99) >= IDLE_PCT);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [CW-1:0] exp_val,
                             input logic [CW-1:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0d, got %0d", name, $signed(exp_val), $signed(act_val));
      err_count++;
    end
  endtask

  // Compare each result item with the oldest expected quaternion
  always @(posedge clk) begin : result_check
    quat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (quat_expected.size() == 0) begin
        $error("result item with no expected quaternion waiting");
        err_count++;
      end else begin
        want = quat_expected.pop_front();
        check_field("comp_zero",  want.comp[0], m_tdata[15:0]);
        check_field("comp_one",   want.comp[1], m_tdata[31:16]);
        check_field("comp_two",   want.comp[2], m_tdata[47:32]);
        check_field("comp_three", want.comp[3], m_tdata[63:48]);
        check_field("tag_ok", CW'(want.ok), CW'(m_tuser));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
`default_nettype wire
